FILE: rtl/gdf_pkg.sv
// Shared types and constants for the diamond fill and ring dilation engine.
`timescale 1ns / 1ps

package gdf_pkg;

	localparam int CFG_W  = 7;
	localparam int CELL_W = 8;

	typedef enum logic [2:0] {
		CMD_WRITE    = 3'd0,
		CMD_READ     = 3'd1,
		CMD_ADD      = 3'd2,
		CMD_SET      = 3'd3,
		CMD_RING     = 3'd4,
		CMD_FRONTIER = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_WAIT,
		ST_DIA,
		ST_RING_RD,
		ST_RING_CHK,
		ST_RING_NB,
		ST_DONE
	} state_t;

	localparam logic [1:0] REG_MAP_WIDTH   = 2'd0;
	localparam logic [1:0] REG_MAP_HEIGHT  = 2'd1;
	localparam logic [1:0] REG_REACH_LIMIT = 2'd2;

	localparam logic [CFG_W-1:0] MAP_WIDTH_RST   = 7'd64;
	localparam logic [CFG_W-1:0] MAP_HEIGHT_RST  = 7'd64;
	localparam logic [CFG_W-1:0] REACH_LIMIT_RST = 7'd120;

	localparam logic [1:0] NB_LEFT  = 2'd0;
	localparam logic [1:0] NB_RIGHT = 2'd1;
	localparam logic [1:0] NB_UP    = 2'd2;
	localparam logic [1:0] NB_DOWN  = 2'd3;

endpackage

FILE: rtl/grid_diamond_fill_and_dilate.sv
// Top level: byte grid engine for diamond add/set, cell access and ring dilation.
//
//   channel  direction  handshake           beat
//   in       to block   in_valid/in_stall   cmd, pos_x, pos_y, radius, value
//   out      from block out_valid/out_stall read_value, frontier_now
//   cfg      to block   APB psel/penable    map_width, map_height, reach_limit
//
// A diamond command scans all w*h cells; a ring pass reads every cell and, for each
// spreading cell, each in-grid neighbor; the RAM takes one read and one write per cycle.
// Reset: registers to 64/64/120, frontier to 0; grid cells are undefined until written.
// A new beat is taken while a result waits; the finished command holds until
// the output register frees.
`timescale 1ns / 1ps

module grid_diamond_fill_and_dilate #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         cmd,
	input  logic [5:0]         pos_x,
	input  logic [5:0]         pos_y,
	input  logic [6:0]         radius,
	input  logic [7:0]         value,

	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         read_value,
	output logic signed [7:0]  frontier_now,

	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int XW   = $clog2(MAX_WIDTH);
	localparam int YW   = $clog2(MAX_HEIGHT);
	localparam int AW   = XW + YW;
	localparam int GWW  = (XW + 1 > 7) ? XW + 1 : 7;
	localparam int GHW  = (YW + 1 > 7) ? YW + 1 : 7;
	localparam int CXW  = (XW > 6) ? XW : 6;
	localparam int CYW  = (YW > 6) ? YW : 6;
	localparam int SW   = ((CXW > CYW) ? CXW : CYW) + 1;

	gdf_pkg::state_t state_q, state_d;

	logic [gdf_pkg::CFG_W-1:0] width_q, height_q, reach_q;
	logic [7:0]                frontier_q, frontier_d;

	gdf_pkg::cmd_t cmd_q, cmd_d;
	logic [5:0]    px_q, px_d, py_q, py_d;
	logic [6:0]    rad_q, rad_d;
	logic [7:0]    val_q, val_d;
	logic          in_grid_q, in_grid_d;
	logic [7:0]    res_rd_q, res_rd_d;

	logic [XW-1:0] x_q, x_d;
	logic [YW-1:0] y_q, y_d;
	logic [1:0]    nb_q, nb_d;
	logic          scan_end_q, scan_end_d;

	logic          v_s1, v_s1_d;
	logic          hit_s1, hit_s1_d;
	logic [AW-1:0] addr_s1, addr_s1_d;

	logic          out_valid_q;
	logic [7:0]    read_value_q;
	logic [7:0]    frontier_out_q;
	logic          load_out;

	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [7:0]    mem_wdata, mem_rdata;

	logic [GWW-1:0] gw, gw_m1;
	logic [GHW-1:0] gh, gh_m1;
	logic           grid_empty;
	logic           in_grid_in;
	logic [AW-1:0]  in_addr, cur_addr;
	logic           x_last, y_last;
	logic [CXW-1:0] dx;
	logic [CYW-1:0] dy;
	logic           dia_hit;
	logic           spread;
	logic [3:0]     nb_ok;
	logic [2:0]     nb_start;
	logic           nb_found;
	logic [1:0]     nb_next;
	logic           ring_adv;

	function automatic logic [AW-1:0] nb_addr(input logic [1:0] k, input logic [XW-1:0] x,
		input logic [YW-1:0] y);
		logic [AW-1:0] a;
		case (k)
			gdf_pkg::NB_LEFT:  a = {y, x - XW'(1)};
			gdf_pkg::NB_RIGHT: a = {y, x + XW'(1)};
			gdf_pkg::NB_UP:    a = {y - YW'(1), x};
			gdf_pkg::NB_DOWN:  a = {y + YW'(1), x};
			default:           a = {y, x};
		endcase
		return a;
	endfunction

	gdf_cell_ram #(
		.AW(AW),
		.DW(gdf_pkg::CELL_W)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// grid geometry
	assign gw = (GWW'(width_q) > GWW'(MAX_WIDTH)) ? GWW'(MAX_WIDTH) : GWW'(width_q);
	assign gh = (GHW'(height_q) > GHW'(MAX_HEIGHT)) ? GHW'(MAX_HEIGHT) : GHW'(height_q);
	assign gw_m1 = gw - GWW'(1);
	assign gh_m1 = gh - GHW'(1);
	assign grid_empty = (width_q == '0) || (height_q == '0);

	assign in_grid_in = (GWW'(pos_x) < gw) && (GHW'(pos_y) < gh);
	assign in_addr    = {YW'(pos_y), XW'(pos_x)};
	assign cur_addr   = {y_q, x_q};
	assign x_last     = (GWW'(x_q) + GWW'(1)) == gw;
	assign y_last     = (GHW'(y_q) + GHW'(1)) == gh;

	// diamond membership
	assign dx = (CXW'(x_q) > CXW'(px_q)) ? CXW'(x_q) - CXW'(px_q) : CXW'(px_q) - CXW'(x_q);
	assign dy = (CYW'(y_q) > CYW'(py_q)) ? CYW'(y_q) - CYW'(py_q) : CYW'(py_q) - CYW'(y_q);
	assign dia_hit = (SW'(dx) + SW'(dy)) <= SW'(rad_q);

	// ring spread test and neighbor walk
	assign spread   = (mem_rdata <= {1'b0, reach_q}) && (mem_rdata != frontier_q);
	assign nb_ok[0] = x_q != '0;
	assign nb_ok[1] = (GWW'(x_q) + GWW'(1)) < gw;
	assign nb_ok[2] = y_q != '0;
	assign nb_ok[3] = (GHW'(y_q) + GHW'(1)) < gh;
	assign nb_start = (state_q == gdf_pkg::ST_RING_NB) ? {1'b0, nb_q} + 3'd1 : 3'd0;

	always_comb begin
		nb_found = 1'b0;
		nb_next  = 2'd0;
		for (int k = 3; k >= 0; k--) begin
			if (3'(k) >= nb_start && nb_ok[k]) begin
				nb_found = 1'b1;
				nb_next  = 2'(k);
			end
		end
	end

	assign load_out = (state_q == gdf_pkg::ST_DONE) && (!out_valid_q || !out_stall);

	always_comb begin
		state_d    = state_q;
		frontier_d = frontier_q;
		cmd_d      = cmd_q;
		px_d       = px_q;
		py_d       = py_q;
		rad_d      = rad_q;
		val_d      = val_q;
		in_grid_d  = in_grid_q;
		res_rd_d   = res_rd_q;
		x_d        = x_q;
		y_d        = y_q;
		nb_d       = nb_q;
		scan_end_d = scan_end_q;
		v_s1_d     = 1'b0;
		hit_s1_d   = hit_s1;
		addr_s1_d  = addr_s1;
		mem_we     = 1'b0;
		mem_waddr  = addr_s1;
		mem_wdata  = val_q;
		mem_re     = 1'b0;
		mem_raddr  = cur_addr;
		ring_adv   = 1'b0;

		case (state_q)
			gdf_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd_d     = gdf_pkg::cmd_t'(cmd);
					px_d      = pos_x;
					py_d      = pos_y;
					rad_d     = radius;
					val_d     = value;
					in_grid_d = in_grid_in;
					res_rd_d  = '0;
					state_d   = gdf_pkg::ST_DONE;
					case (gdf_pkg::cmd_t'(cmd))
						gdf_pkg::CMD_WRITE: begin
							mem_we    = in_grid_in;
							mem_waddr = in_addr;
							mem_wdata = value;
						end
						gdf_pkg::CMD_READ: begin
							mem_re    = 1'b1;
							mem_raddr = in_addr;
							state_d   = gdf_pkg::ST_RD_WAIT;
						end
						gdf_pkg::CMD_ADD, gdf_pkg::CMD_SET: begin
							if (!grid_empty) begin
								x_d        = '0;
								y_d        = '0;
								scan_end_d = 1'b0;
								state_d    = gdf_pkg::ST_DIA;
							end
						end
						gdf_pkg::CMD_RING: begin
							if (grid_empty) begin
								frontier_d = frontier_q + 8'd1;
							end else begin
								x_d     = gw_m1[XW-1:0];
								y_d     = gh_m1[YW-1:0];
								state_d = gdf_pkg::ST_RING_RD;
							end
						end
						gdf_pkg::CMD_FRONTIER: begin
							frontier_d = value;
						end
						default: begin
						end
					endcase
				end
			end
			gdf_pkg::ST_RD_WAIT: begin
				res_rd_d = in_grid_q ? mem_rdata : '0;
				state_d  = gdf_pkg::ST_DONE;
			end
			gdf_pkg::ST_DIA: begin
				if (v_s1 && hit_s1) begin
					mem_we    = 1'b1;
					mem_waddr = addr_s1;
					mem_wdata = (cmd_q == gdf_pkg::CMD_ADD) ? mem_rdata + val_q : val_q;
				end
				if (!scan_end_q) begin
					mem_re    = 1'b1;
					mem_raddr = cur_addr;
					v_s1_d    = 1'b1;
					addr_s1_d = cur_addr;
					hit_s1_d  = dia_hit;
					if (x_last) begin
						x_d = '0;
						if (y_last) begin
							scan_end_d = 1'b1;
						end else begin
							y_d = y_q + YW'(1);
						end
					end else begin
						x_d = x_q + XW'(1);
					end
				end else if (!v_s1) begin
					state_d = gdf_pkg::ST_DONE;
				end
			end
			gdf_pkg::ST_RING_RD: begin
				mem_re    = 1'b1;
				mem_raddr = cur_addr;
				state_d   = gdf_pkg::ST_RING_CHK;
			end
			gdf_pkg::ST_RING_CHK: begin
				if (spread && nb_found) begin
					mem_re    = 1'b1;
					mem_raddr = nb_addr(nb_next, x_q, y_q);
					nb_d      = nb_next;
					state_d   = gdf_pkg::ST_RING_NB;
				end else begin
					ring_adv = 1'b1;
				end
			end
			gdf_pkg::ST_RING_NB: begin
				if (mem_rdata[7]) begin
					mem_we    = 1'b1;
					mem_waddr = nb_addr(nb_q, x_q, y_q);
					mem_wdata = frontier_q;
				end
				if (nb_found) begin
					mem_re    = 1'b1;
					mem_raddr = nb_addr(nb_next, x_q, y_q);
					nb_d      = nb_next;
				end else begin
					ring_adv = 1'b1;
				end
			end
			gdf_pkg::ST_DONE: begin
				if (load_out) begin
					state_d = gdf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gdf_pkg::ST_IDLE;
			end
		endcase

		// reverse raster step of the ring pass
		if (ring_adv) begin
			if (x_q != '0) begin
				x_d     = x_q - XW'(1);
				state_d = gdf_pkg::ST_RING_RD;
			end else if (y_q != '0) begin
				x_d     = gw_m1[XW-1:0];
				y_d     = y_q - YW'(1);
				state_d = gdf_pkg::ST_RING_RD;
			end else begin
				frontier_d = frontier_q + 8'd1;
				state_d    = gdf_pkg::ST_DONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gdf_pkg::ST_IDLE;
			frontier_q  <= '0;
			scan_end_q  <= 1'b0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			frontier_q <= frontier_d;
			scan_end_q <= scan_end_d;
			v_s1       <= v_s1_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmd_q     <= cmd_d;
		px_q      <= px_d;
		py_q      <= py_d;
		rad_q     <= rad_d;
		val_q     <= val_d;
		in_grid_q <= in_grid_d;
		res_rd_q  <= res_rd_d;
		x_q       <= x_d;
		y_q       <= y_d;
		nb_q      <= nb_d;
		hit_s1    <= hit_s1_d;
		addr_s1   <= addr_s1_d;
		if (load_out) begin
			read_value_q   <= res_rd_q;
			frontier_out_q <= frontier_q;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= gdf_pkg::MAP_WIDTH_RST;
			height_q <= gdf_pkg::MAP_HEIGHT_RST;
			reach_q  <= gdf_pkg::REACH_LIMIT_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				gdf_pkg::REG_MAP_WIDTH:   width_q  <= pwdata[6:0];
				gdf_pkg::REG_MAP_HEIGHT:  height_q <= pwdata[6:0];
				gdf_pkg::REG_REACH_LIMIT: reach_q  <= pwdata[6:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			gdf_pkg::REG_MAP_WIDTH:   prdata = {25'd0, width_q};
			gdf_pkg::REG_MAP_HEIGHT:  prdata = {25'd0, height_q};
			gdf_pkg::REG_REACH_LIMIT: prdata = {25'd0, reach_q};
			default:                  prdata = '0;
		endcase
	end

	assign pready       = 1'b1;
	assign in_stall     = state_q != gdf_pkg::ST_IDLE;
	assign out_valid    = out_valid_q;
	assign read_value   = read_value_q;
	assign frontier_now = signed'(frontier_out_q);

`ifndef SYNTHESIS
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re && (mem_waddr == mem_raddr)))
		else $error("cell read and write hit the same address in one cycle");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == gdf_pkg::ST_DONE))
		else $error("result beat raised outside the done state");

	a_frontier_src: assert property (@(posedge clk) disable iff (!arst_n)
		(frontier_q != $past(frontier_q)) |->
		($past(state_q == gdf_pkg::ST_IDLE) || $past(state_q == gdf_pkg::ST_RING_CHK)
		|| $past(state_q == gdf_pkg::ST_RING_NB)))
		else $error("frontier changed outside a command start or ring pass end");
`endif

endmodule

FILE: rtl/gdf_cell_ram.sv
// Single-port-write, single-port-read cell memory with registered read data.
`timescale 1ns / 1ps

module gdf_cell_ram #(
	parameter int AW = 12,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [(1 << AW)];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: tb/gdf_grid_checker.sv
// Checker for the grid engine: mirrors the grid and frontier, predicts each reply and compares.
`timescale 1ns / 1ps

module gdf_grid_checker #(
	parameter int MAX_W = 64,
	parameter int MAX_H = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [2:0]        cmd,
	input  logic [5:0]        pos_x,
	input  logic [5:0]        pos_y,
	input  logic [6:0]        radius,
	input  logic [7:0]        value,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [7:0]        read_value,
	input  logic signed [7:0] frontier_now,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	input  logic              pready,
	output int                errors,
	output int                pending
);

	typedef struct packed {
		logic [7:0]        rd;
		logic signed [7:0] fr;
	} reply_t;

	reply_t                    reply_q[$];
	logic [7:0]                grid_mem [0:MAX_W*MAX_H-1];
	logic [7:0]                front;
	logic [gdf_pkg::CFG_W-1:0] cfg_width;
	logic [gdf_pkg::CFG_W-1:0] cfg_height;
	logic [gdf_pkg::CFG_W-1:0] cfg_reach;

	function automatic int grid_w();
		return (cfg_width > MAX_W) ? MAX_W : int'(cfg_width);
	endfunction

	function automatic int grid_h();
		return (cfg_height > MAX_H) ? MAX_H : int'(cfg_height);
	endfunction

	task automatic diamond_fill(input int cx, input int cy, input int r, input logic [7:0] v,
			input logic add);
		int w, h, x, y, dx, dy;
		w = grid_w();
		h = grid_h();
		for (y = 0; y < h; y++) begin
			for (x = 0; x < w; x++) begin
				dx = (x > cx) ? x - cx : cx - x;
				dy = (y > cy) ? y - cy : cy - y;
				if (dx + dy <= r) begin
					if (add)
						grid_mem[y*MAX_W + x] = grid_mem[y*MAX_W + x] + v;
					else
						grid_mem[y*MAX_W + x] = v;
				end
			end
		end
	endtask

	task automatic mark_cell(input int x, input int y);
		if (grid_mem[y*MAX_W + x][7])
			grid_mem[y*MAX_W + x] = front;
	endtask

	// in-place sweep, last row/column first
	task automatic ring_pass();
		int w, h, x, y;
		logic [7:0] c;
		w = grid_w();
		h = grid_h();
		for (y = h - 1; y >= 0; y--) begin
			for (x = w - 1; x >= 0; x--) begin
				c = grid_mem[y*MAX_W + x];
				if (c <= cfg_reach && c != front) begin
					if (x != 0)
						mark_cell(x - 1, y);
					if (x + 1 < w)
						mark_cell(x + 1, y);
					if (y != 0)
						mark_cell(x, y - 1);
					if (y + 1 < h)
						mark_cell(x, y + 1);
				end
			end
		end
		front = front + 8'd1;
	endtask

	task automatic run_command(input logic [2:0] c, input int x, input int y, input int r,
			input logic [7:0] v, output reply_t rep);
		logic in_grid;
		rep.rd = '0;
		in_grid = (x < grid_w()) && (y < grid_h());
		case (c)
		gdf_pkg::CMD_WRITE: begin
			if (in_grid)
				grid_mem[y*MAX_W + x] = v;
		end
		gdf_pkg::CMD_READ: begin
			if (in_grid)
				rep.rd = grid_mem[y*MAX_W + x];
		end
		gdf_pkg::CMD_ADD:      diamond_fill(x, y, r, v, 1'b1);
		gdf_pkg::CMD_SET:      diamond_fill(x, y, r, v, 1'b0);
		gdf_pkg::CMD_RING:     ring_pass();
		gdf_pkg::CMD_FRONTIER: front = v;
		default: ;
		endcase
		rep.fr = front;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		reply_t want;
		if (!arst_n) begin
			reply_q.delete();
			front = '0;
			cfg_width = gdf_pkg::MAP_WIDTH_RST;
			cfg_height = gdf_pkg::MAP_HEIGHT_RST;
			cfg_reach = gdf_pkg::REACH_LIMIT_RST;
			errors = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
				gdf_pkg::REG_MAP_WIDTH:   cfg_width = pwdata[gdf_pkg::CFG_W-1:0];
				gdf_pkg::REG_MAP_HEIGHT:  cfg_height = pwdata[gdf_pkg::CFG_W-1:0];
				gdf_pkg::REG_REACH_LIMIT: cfg_reach = pwdata[gdf_pkg::CFG_W-1:0];
				default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (reply_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected beat read_value=%02h frontier_now=%0d",
							$realtime, read_value, frontier_now);
				end else begin
					want = reply_q.pop_front();
					if (read_value !== want.rd || frontier_now !== want.fr) begin
						errors++;
						if (errors <= 10)
							$display("%0t: mismatch read_value exp %02h got %02h, frontier_now exp %0d got %0d",
								$realtime, want.rd, read_value, want.fr, frontier_now);
					end
				end
			end
			if (in_valid && !in_stall) begin
				run_command(cmd, int'(pos_x), int'(pos_y), int'(radius), value, want);
				reply_q.push_back(want);
			end
			pending = reply_q.size();
		end
	end

endmodule

FILE: tb/tb_grid_diamond_fill_and_dilate.sv
// Testbench top for the grid engine: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb_grid_diamond_fill_and_dilate;

	localparam int LIMIT = 1500000;
	localparam logic [2:0] CMD_SPARE_LO = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [2:0]        cmd;
	logic [5:0]        pos_x;
	logic [5:0]        pos_y;
	logic [6:0]        radius;
	logic [7:0]        value;
	logic              out_valid;
	logic              out_stall;
	logic [7:0]        read_value;
	logic signed [7:0] frontier_now;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [3:0]        paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	int   fail_count;
	int   pending;
	int   cycles;
	int   cur_w;
	logic calm = 1'b0;
	logic hold_req;

	always #1 clk = ~clk;

	grid_diamond_fill_and_dilate u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .pos_x(pos_x), .pos_y(pos_y), .radius(radius), .value(value),
		.out_valid(out_valid), .out_stall(out_stall),
		.read_value(read_value), .frontier_now(frontier_now),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	gdf_grid_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .pos_x(pos_x), .pos_y(pos_y), .radius(radius), .value(value),
		.out_valid(out_valid), .out_stall(out_stall),
		.read_value(read_value), .frontier_now(frontier_now),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.errors(fail_count), .pending(pending)
	);

	// drains outstanding replies, then writes all three registers
	task automatic program_grid(input int w, input int h, input int reach);
		logic [gdf_pkg::CFG_W-1:0] vals [3];
		logic [1:0]                idx [3];
		int                        i;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		vals[0] = w[gdf_pkg::CFG_W-1:0];
		vals[1] = h[gdf_pkg::CFG_W-1:0];
		vals[2] = reach[gdf_pkg::CFG_W-1:0];
		idx[0] = gdf_pkg::REG_MAP_WIDTH;
		idx[1] = gdf_pkg::REG_MAP_HEIGHT;
		idx[2] = gdf_pkg::REG_REACH_LIMIT;
		for (i = 0; i < 3; i++) begin
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b1;
			paddr <= {idx[i], 2'b00};
			pwdata <= {{(32-gdf_pkg::CFG_W){1'b0}}, vals[i]};
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cur_w = (w > 63) ? 63 : w;
	endtask

	task automatic send_item(input logic [2:0] c, input logic [5:0] x, input logic [5:0] y,
			input logic [6:0] r, input logic [7:0] v);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		pos_x <= x;
		pos_y <= y;
		radius <= r;
		value <= v;
		do @(posedge clk); while (in_stall);
	endtask

	// receiver: random stall bursts, plus one long hold-off to back up the block
	initial begin : receiver
		logic held;
		held = 1'b0;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				out_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("grid_diamond_fill_and_dilate regression: fail");
		$finish;
	end

	initial begin : stimulus
		int         ph, n, roll, pick;
		logic [2:0] c;
		logic [5:0] x, y;
		logic [6:0] r;
		logic [7:0] v;
		logic [6:0] reach;

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		cmd <= gdf_pkg::CMD_WRITE;
		pos_x <= '0;
		pos_y <= '0;
		radius <= '0;
		value <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		hold_req <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full grid; first fill writes every cell
		program_grid(64, 64, 120);
		send_item(gdf_pkg::CMD_SET, 0, 0, 127, 8'h80);
		send_item(gdf_pkg::CMD_WRITE, 0, 0, 0, 8'h00);
		send_item(gdf_pkg::CMD_WRITE, 63, 63, 0, 8'hFF);
		send_item(gdf_pkg::CMD_WRITE, 63, 0, 0, 8'h7F);
		send_item(gdf_pkg::CMD_READ, 63, 63, 0, 8'h00);
		send_item(gdf_pkg::CMD_READ, 0, 63, 0, 8'h00);
		send_item(gdf_pkg::CMD_ADD, 32, 32, 5, 8'hFF);
		send_item(gdf_pkg::CMD_READ, 32, 32, 0, 8'h00);
		send_item(gdf_pkg::CMD_FRONTIER, 0, 0, 0, 8'h05);
		send_item(gdf_pkg::CMD_RING, 0, 0, 0, 8'h00);
		send_item(gdf_pkg::CMD_READ, 1, 0, 0, 8'h00);
		send_item(CMD_SPARE_LO, 0, 0, 0, 8'h00);
		send_item(CMD_SPARE_HI, 63, 63, 127, 8'hFF);
		send_item(gdf_pkg::CMD_FRONTIER, 0, 0, 0, 8'hFF);

		// empty grid: zero width, then zero height
		program_grid(0, 64, 0);
		send_item(gdf_pkg::CMD_WRITE, 0, 0, 0, 8'h11);
		send_item(gdf_pkg::CMD_READ, 0, 0, 0, 8'h00);
		send_item(gdf_pkg::CMD_ADD, 0, 0, 127, 8'h01);
		send_item(gdf_pkg::CMD_RING, 0, 0, 0, 8'h00);
		program_grid(64, 0, 60);
		send_item(gdf_pkg::CMD_READ, 5, 0, 0, 8'h00);
		send_item(gdf_pkg::CMD_RING, 0, 0, 0, 8'h00);

		// oversized dimensions clip to the array
		program_grid(127, 127, 127);
		send_item(gdf_pkg::CMD_WRITE, 63, 62, 0, 8'h01);
		send_item(gdf_pkg::CMD_READ, 63, 62, 0, 8'h00);
		send_item(gdf_pkg::CMD_SET, 63, 63, 1, 8'h7F);

		// diamond centered off the grid
		program_grid(3, 2, 127);
		send_item(gdf_pkg::CMD_SET, 5, 1, 3, 8'h42);
		send_item(gdf_pkg::CMD_READ, 2, 1, 0, 8'h00);
		send_item(gdf_pkg::CMD_READ, 5, 1, 0, 8'h00);
		send_item(gdf_pkg::CMD_RING, 0, 0, 0, 8'h00);
		send_item(gdf_pkg::CMD_READ, 1, 1, 0, 8'h00);

		for (ph = 0; ph < 6; ph++) begin
			if (ph == 5)
				calm = 1'b1;
			reach = 7'($urandom_range(0, 127));
			program_grid(int'($urandom_range(1, (ph == 3) ? 24 : 12)),
				int'($urandom_range(1, 12)), int'(reach));
			if (ph == 0)
				hold_req <= 1'b1;
			for (n = 0; n < 20; n++) begin
				roll = int'($urandom_range(0, 99));
				if (roll < 25)
					c = gdf_pkg::CMD_WRITE;
				else if (roll < 45)
					c = gdf_pkg::CMD_READ;
				else if (roll < 60)
					c = gdf_pkg::CMD_ADD;
				else if (roll < 70)
					c = gdf_pkg::CMD_SET;
				else if (roll < 85)
					c = gdf_pkg::CMD_RING;
				else if (roll < 95)
					c = gdf_pkg::CMD_FRONTIER;
				else
					c = ($urandom_range(0, 1) != 0) ? CMD_SPARE_LO : CMD_SPARE_HI;
				// mostly near the grid, now and then anywhere
				x = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
					: 6'($urandom_range(0, cur_w));
				y = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
					: 6'($urandom_range(0, 13));
				pick = int'($urandom_range(0, 9));
				if (pick < 7)
					r = 7'($urandom_range(0, 4));
				else if (pick < 9)
					r = 7'($urandom_range(0, 16));
				else
					r = 7'($urandom_range(0, 127));
				// spreaders and negative cells so ring passes do work
				pick = int'($urandom_range(0, 9));
				if (pick < 4)
					v = 8'($urandom_range(0, reach));
				else if (pick < 8)
					v = 8'($urandom_range(128, 255));
				else
					v = 8'($urandom_range(0, 255));
				send_item(c, x, y, r, v);
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("grid_diamond_fill_and_dilate regression: pass");
		else
			$display("grid_diamond_fill_and_dilate regression: fail");
		$finish;
	end

endmodule

FILE: grid_diamond_fill_and_dilate.f
rtl/gdf_pkg.sv
rtl/gdf_cell_ram.sv
rtl/grid_diamond_fill_and_dilate.sv
tb/gdf_grid_checker.sv
tb/tb_grid_diamond_fill_and_dilate.sv
